[rtl/core/crc_checked_command_deframer_defines.svh]
// Assertion macros shared by the deframer RTL modules.
// Each macro assumes signals named clk and rst_n exist in the including module.
`ifndef CRC_CHECKED_COMMAND_DEFRAMER_DEFINES_SVH
`define CRC_CHECKED_COMMAND_DEFRAMER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ccd_pkg.sv]
// Shared types, codes and CRC helper for the CRC-checked command deframer.
// No dependencies; used by all rtl/core modules.
`default_nettype none

package ccd_pkg;

  localparam logic [7:0]  START_BYTE = 8'h02;
  localparam logic [7:0]  END_BYTE   = 8'h03;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [7:0]  HEAD_DEPTH = 8'd5;
  localparam logic [7:0]  ARG_MIN_LEN = 8'd5;
  localparam logic [7:0]  MAX_LEN_RESET = 8'hFF;

  localparam logic [7:0] CMD_VERSION = 8'd0;
  localparam logic [7:0] CMD_VALUES  = 8'd4;
  localparam logic [7:0] CMD_DUTY    = 8'd5;
  localparam logic [7:0] CMD_CURRENT = 8'd6;
  localparam logic [7:0] CMD_RPM     = 8'd8;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_VERSION = 3'd1;
  localparam logic [2:0] ACT_VALUES  = 3'd2;
  localparam logic [2:0] ACT_DUTY    = 3'd3;
  localparam logic [2:0] ACT_CURRENT = 3'd4;
  localparam logic [2:0] ACT_RPM     = 3'd5;

  localparam logic REG_MAX_LEN = 1'b0;

  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         command_byte;
    logic signed [31:0] argument;
    logic [7:0]         frame_length;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [2:0] decode_action(input logic [7:0] cmd, input logic [7:0] len);
    logic long_enough;
    long_enough = (len >= ARG_MIN_LEN);
    case (cmd)
      CMD_VERSION: return ACT_VERSION;
      CMD_VALUES:  return ACT_VALUES;
      CMD_DUTY:    return long_enough ? ACT_DUTY : ACT_NONE;
      CMD_CURRENT: return long_enough ? ACT_CURRENT : ACT_NONE;
      CMD_RPM:     return long_enough ? ACT_RPM : ACT_NONE;
      default:     return ACT_NONE;
    endcase
  endfunction

endpackage

`default_nettype wire

[rtl/core/crc_checked_command_deframer.sv]
// Top level of the CRC-checked command deframer.
// Instantiates ccd_regs, ccd_frame and ccd_out; depends on ccd_pkg.
`default_nettype none

// Accepts one received byte per clock and recognizes frames of the form
// start 0x02, length (1 to max_payload_length), payload, big-endian CRC-16
// (poly 0x1021, init 0) and end 0x03. A valid frame produces one result
// transaction holding the command byte, the decoded action, the big-endian
// signed argument from payload bytes one to four (zero for payloads shorter
// than five bytes) and the payload length. Each byte goes through an input
// register and a stage that runs the frame state machine and the byte-wide
// CRC update, so the sustained rate is one byte per clock; the result for a
// frame is registered in the output register when its end byte leaves the
// input register. A result that waits for out_ready holds the input
// register, so in_ready drops until the result transaction completes.
// max_payload_length sits at byte address 0 of the APB port, reset value
// 255; write it only while no frame is in progress.
module crc_checked_command_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [2:0]  out_action,
  output logic      [7:0]  out_command_byte,
  output logic signed [31:0] out_argument,
  output logic      [7:0]  out_frame_length,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic             slot_free;
  logic             res_valid;
  logic [7:0]       max_len;
  ccd_pkg::result_t res;
  ccd_pkg::result_t out_res;

  ccd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_len (max_len)
  );

  ccd_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .max_len    (max_len),
    .slot_free  (slot_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  ccd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_action       = out_res.action;
  assign out_command_byte = out_res.command_byte;
  assign out_argument     = out_res.argument;
  assign out_frame_length = out_res.frame_length;

endmodule

`default_nettype wire

[rtl/core/ccd_regs.sv]
// APB-style configuration register bank for the deframer (max payload length).
// Depends on ccd_pkg.
`default_nettype none

module ccd_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [7:0]  max_len
);

  logic [7:0] max_len_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == ccd_pkg::REG_MAX_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= ccd_pkg::MAX_LEN_RESET;
    end else if (wr_en) begin
      max_len_r <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == ccd_pkg::REG_MAX_LEN) begin
      prdata = {24'd0, max_len_r};
    end
  end

  assign max_len = max_len_r;

endmodule

`default_nettype wire

[rtl/core/ccd_frame.sv]
// Input register, frame state machine, CRC-16 and head byte capture.
// Depends on ccd_pkg and crc_checked_command_deframer_defines.svh.
`default_nettype none
`include "crc_checked_command_deframer_defines.svh"

module ccd_frame (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic [7:0] max_len,
  input  wire logic       slot_free,
  output logic            res_valid,
  output ccd_pkg::result_t res
);

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_CRC_HI  = 3'd3;
  localparam logic [2:0] PH_CRC_LO  = 3'd4;
  localparam logic [2:0] PH_END     = 3'd5;

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        advance;

  logic [2:0]  phase_r,   phase_nxt;
  logic [7:0]  exp_len_r, exp_len_nxt;
  logic [7:0]  idx_r,     idx_nxt;
  logic [15:0] crc_r,     crc_nxt;
  logic [15:0] rcv_crc_r, rcv_crc_nxt;
  logic [7:0]  head_r [5];
  logic        head_wr;
  logic        frame_ok;

  assign advance  = in_valid_r && slot_free;
  assign in_ready = !in_valid_r || advance;
  assign head_wr  = advance && (phase_r == PH_PAYLOAD) && (idx_r < ccd_pkg::HEAD_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    exp_len_nxt = exp_len_r;
    idx_nxt     = idx_r;
    crc_nxt     = crc_r;
    rcv_crc_nxt = rcv_crc_r;
    frame_ok    = 1'b0;
    if (advance) begin
      case (phase_r)
        PH_LEN: begin
          exp_len_nxt = in_byte_r;
          idx_nxt     = 8'd0;
          crc_nxt     = 16'd0;
          if ((in_byte_r == 8'd0) || (in_byte_r > max_len)) begin
            phase_nxt = PH_START;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_nxt = ccd_pkg::crc_byte(crc_r, in_byte_r);
          if ({1'b0, idx_r} + 9'd1 >= {1'b0, exp_len_r}) begin
            idx_nxt   = exp_len_r;
            phase_nxt = PH_CRC_HI;
          end else begin
            idx_nxt = idx_r + 8'd1;
          end
        end
        PH_CRC_HI: begin
          rcv_crc_nxt = {in_byte_r, 8'h00};
          phase_nxt   = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          rcv_crc_nxt = {rcv_crc_r[15:8], in_byte_r};
          phase_nxt   = PH_END;
        end
        PH_END: begin
          frame_ok  = (in_byte_r == ccd_pkg::END_BYTE) && (rcv_crc_r == crc_r);
          phase_nxt = PH_START;
        end
        default: begin
          phase_nxt = (in_byte_r == ccd_pkg::START_BYTE) ? PH_LEN : PH_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      exp_len_r <= 8'd0;
      idx_r     <= 8'd0;
      crc_r     <= 16'd0;
      rcv_crc_r <= 16'd0;
    end else begin
      phase_r   <= phase_nxt;
      exp_len_r <= exp_len_nxt;
      idx_r     <= idx_nxt;
      crc_r     <= crc_nxt;
      rcv_crc_r <= rcv_crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (head_wr) begin
      head_r[idx_r[2:0]] <= in_byte_r;
    end
  end

  assign res_valid         = frame_ok;
  assign res.action        = ccd_pkg::decode_action(head_r[0], exp_len_r);
  assign res.command_byte  = head_r[0];
  assign res.argument      = (exp_len_r >= ccd_pkg::ARG_MIN_LEN) ?
                             {head_r[1], head_r[2], head_r[3], head_r[4]} : 32'sd0;
  assign res.frame_length  = exp_len_r;

  `CCD_ASSERT_NOW(a_res_only_at_end, res_valid, (phase_r == PH_END) && slot_free,
    "result raised outside end phase or without a free slot")
  `CCD_ASSERT_NOW(a_idx_in_payload, phase_r == PH_PAYLOAD, idx_r < exp_len_r,
    "payload index reached expected length")
  `CCD_ASSERT_NEXT(a_crc_hi_to_lo, advance && (phase_r == PH_CRC_HI), phase_r == PH_CRC_LO,
    "CRC high byte not followed by CRC low phase")

endmodule

`default_nettype wire

[rtl/core/ccd_out.sv]
// Result register for the deframer output channel.
// Depends on ccd_pkg and crc_checked_command_deframer_defines.svh.
`default_nettype none
`include "crc_checked_command_deframer_defines.svh"

module ccd_out (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             res_valid,
  input  wire ccd_pkg::result_t res,
  output logic                  slot_free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ccd_pkg::result_t      out_res
);

  logic             out_valid_r;
  ccd_pkg::result_t out_res_r;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `CCD_ASSERT_NEXT(a_stall_holds, out_valid_r && !out_ready, out_valid_r && $stable(out_res_r),
    "pending result lost or changed while stalled")

endmodule

`default_nettype wire

[dv/tb_crc_checked_command_deframer.sv]
// Self-checking testbench for crc_checked_command_deframer: directed and random
// byte streams (clean, corrupted and noise frames) with a predictor in a scoreboard.
// Depends on ccd_pkg and the deframer RTL.
module tb_crc_checked_command_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;

  typedef enum logic [2:0] {HUNT, LEN_BYTE, BODY, CRC_HI, CRC_LO, TAIL} rx_phase_t;
  typedef enum {CLEAN, BAD_CRC, BAD_END} frame_flaw_t;

  class frame_tracker_t;
    rx_phase_t   phase;
    logic [7:0]  max_len;
    logic [7:0]  want_len;
    logic [7:0]  idx;
    logic [15:0] crc_acc;
    logic [15:0] crc_got;
    logic [7:0]  head [5];
    ccd_pkg::result_t pending_cmds [$];
    int          errors;

    function new();
      phase   = HUNT;
      max_len = ccd_pkg::MAX_LEN_RESET;
      want_len = '0;
      idx     = '0;
      crc_acc = '0;
      crc_got = '0;
      errors  = 0;
    endfunction

    static function logic [15:0] crc16_next(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c = {c[14:0], 1'b0};
        if (fb) begin
          c = c ^ ccd_pkg::CRC_POLY;
        end
      end
      return c;
    endfunction

    function logic [2:0] action_for(logic [7:0] cmd, logic [7:0] len);
      logic long_frame;
      long_frame = (len >= ccd_pkg::ARG_MIN_LEN);
      case (cmd)
        ccd_pkg::CMD_VERSION: return ccd_pkg::ACT_VERSION;
        ccd_pkg::CMD_VALUES:  return ccd_pkg::ACT_VALUES;
        ccd_pkg::CMD_DUTY:    return long_frame ? ccd_pkg::ACT_DUTY : ccd_pkg::ACT_NONE;
        ccd_pkg::CMD_CURRENT: return long_frame ? ccd_pkg::ACT_CURRENT : ccd_pkg::ACT_NONE;
        ccd_pkg::CMD_RPM:     return long_frame ? ccd_pkg::ACT_RPM : ccd_pkg::ACT_NONE;
        default:              return ccd_pkg::ACT_NONE;
      endcase
    endfunction

    function void set_max(logic [7:0] v);
      max_len = v;
    endfunction

    function int pending_count();
      return pending_cmds.size();
    endfunction

    function void take_byte(logic [7:0] b);
      ccd_pkg::result_t r;
      case (phase)
        LEN_BYTE: begin
          want_len = b;
          idx = '0;
          crc_acc = '0;
          phase = (b == 8'd0 || b > max_len) ? HUNT : BODY;
        end
        BODY: begin
          if (idx < ccd_pkg::HEAD_DEPTH) begin
            head[idx[2:0]] = b;
          end
          crc_acc = crc16_next(crc_acc, b);
          if (int'(idx) + 1 >= int'(want_len)) begin
            idx = want_len;
            phase = CRC_HI;
          end else begin
            idx = idx + 8'd1;
          end
        end
        CRC_HI: begin
          crc_got = {b, 8'h00};
          phase = CRC_LO;
        end
        CRC_LO: begin
          crc_got[7:0] = b;
          phase = TAIL;
        end
        TAIL: begin
          if (b == ccd_pkg::END_BYTE && crc_got == crc_acc) begin
            r.action       = action_for(head[0], want_len);
            r.command_byte = head[0];
            r.argument     = (want_len >= ccd_pkg::ARG_MIN_LEN) ?
                             {head[1], head[2], head[3], head[4]} : '0;
            r.frame_length = want_len;
            pending_cmds.push_back(r);
          end
          phase = HUNT;
        end
        default: begin
          phase = (b == ccd_pkg::START_BYTE) ? LEN_BYTE : HUNT;
        end
      endcase
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    endfunction

    function void match_result(logic [2:0] act, logic [7:0] cmd, logic [31:0] arg,
                               logic [7:0] len);
      ccd_pkg::result_t w;
      if (pending_cmds.size() == 0) begin
        errors++;
        $display("%0t: result with none pending, expected nothing,", $time,
                 " got action %0d cmd 0x%0h arg 0x%0h len %0d", act, cmd, arg, len);
        return;
      end
      w = pending_cmds.pop_front();
      check_field("action", 32'(w.action), 32'(act));
      check_field("command_byte", 32'(w.command_byte), 32'(cmd));
      check_field("argument", w.argument, arg);
      check_field("frame_length", 32'(w.frame_length), 32'(len));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_action;
  logic [7:0]  out_command_byte;
  logic signed [31:0] out_argument;
  logic [7:0]  out_frame_length;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  frame_tracker_t book = new();
  bit          steady = 1'b0;
  bit          hold_request = 1'b0;
  int          bytes_sent = 0;
  logic [7:0]  cur_max = ccd_pkg::MAX_LEN_RESET;

  crc_checked_command_deframer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_action       (out_action),
    .out_command_byte (out_command_byte),
    .out_argument     (out_argument),
    .out_frame_length (out_frame_length),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #4 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_cmd();
    case ($urandom_range(0, 9))
      0:       return ccd_pkg::CMD_VERSION;
      1:       return ccd_pkg::CMD_VALUES;
      2:       return ccd_pkg::CMD_DUTY;
      3:       return ccd_pkg::CMD_CURRENT;
      4:       return ccd_pkg::CMD_RPM;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void build_frame(input int len, input logic [7:0] cmd,
                                      input logic [31:0] arg, input frame_flaw_t flaw,
                                      output logic [7:0] q [$]);
    logic [7:0]  b;
    logic [15:0] crc;
    q = {};
    crc = '0;
    q.push_back(ccd_pkg::START_BYTE);
    q.push_back(8'(len));
    for (int i = 0; i < len; i++) begin
      if (i == 0) b = cmd;
      else if (i <= 4) b = arg[8*(4-i) +: 8];
      else b = 8'($urandom_range(0, 255));
      crc = frame_tracker_t::crc16_next(crc, b);
      q.push_back(b);
    end
    if (flaw == BAD_CRC) begin
      crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    end
    q.push_back(crc[15:8]);
    q.push_back(crc[7:0]);
    q.push_back((flaw == BAD_END) ? (ccd_pkg::END_BYTE ^ 8'($urandom_range(1, 255))) :
                ccd_pkg::END_BYTE);
  endfunction

  // hold valid across back-to-back transactions; drop it only for a gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = steady ? 0 : (($urandom_range(0, 9) < 6) ? 0 : idle_len());
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    book.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input int len, input logic [7:0] cmd, input logic [31:0] arg,
                            input frame_flaw_t flaw);
    logic [7:0] q [$];
    build_frame(len, cmd, arg, flaw, q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (book.pending_count() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [7:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ccd_pkg::REG_MAX_LEN, 2'b00};
    pwdata  <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    book.set_max(v);
    cur_max = v;
  endtask

  task automatic run_mixed(input int count);
    int stop;
    int r;
    int len;
    int cap;
    frame_flaw_t flaw;
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      r = $urandom_range(0, 99);
      cap = (cur_max < 12) ? cur_max : 12;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, cur_max) : $urandom_range(1, cap);
      flaw = CLEAN;
      if (r < 8) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
        continue;
      end else if (r < 80) begin
        flaw = CLEAN;
      end else if (r < 88) begin
        flaw = BAD_CRC;
      end else if (r < 94) begin
        flaw = BAD_END;
      end else begin
        len = (cur_max == 8'd255 || $urandom_range(0, 1) == 0) ? 0 :
              $urandom_range(cur_max + 1, 255);
      end
      send_frame(len, pick_cmd(), $urandom, flaw);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      book.match_result(out_action, out_command_byte, out_argument, out_frame_length);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [7:0] q [$];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_max_len(8'd255);
    send_frame(1, ccd_pkg::CMD_VERSION, 32'h0, CLEAN);
    send_frame(1, ccd_pkg::CMD_VALUES, 32'h0, CLEAN);
    send_frame(4, ccd_pkg::CMD_DUTY, 32'h1234_5678, CLEAN);
    send_frame(5, ccd_pkg::CMD_DUTY, 32'h8000_0000, CLEAN);
    send_frame(5, ccd_pkg::CMD_CURRENT, 32'h7FFF_FFFF, CLEAN);
    send_frame(6, ccd_pkg::CMD_RPM, $urandom, CLEAN);
    send_frame(5, 8'hFF, 32'hFFFF_FFFF, CLEAN);
    send_frame(5, ccd_pkg::CMD_RPM, $urandom, BAD_CRC);
    send_frame(5, ccd_pkg::CMD_DUTY, $urandom, BAD_END);
    send_frame(0, ccd_pkg::CMD_VERSION, 32'h0, CLEAN);
    send_frame(255, ccd_pkg::CMD_CURRENT, $urandom, CLEAN);

    // shrink the limit between the length byte and the payload
    build_frame(10, ccd_pkg::CMD_DUTY, $urandom, CLEAN, q);
    for (int i = 0; i < 2; i++) send_byte(q[i]);
    wait_drain();
    write_max_len(8'd3);
    for (int i = 2; i < q.size(); i++) send_byte(q[i]);

    wait_drain();
    write_max_len(8'd1);
    send_frame(1, ccd_pkg::CMD_VALUES, 32'h0, CLEAN);
    send_frame(2, ccd_pkg::CMD_VALUES, 32'h0, CLEAN);
    wait_drain();
    write_max_len(8'd0);
    send_frame(1, ccd_pkg::CMD_VERSION, 32'h0, CLEAN);

    wait_drain();
    write_max_len(8'd255);
    hold_request = 1'b1;
    repeat (20) send_frame($urandom_range(1, 4), pick_cmd(), $urandom, CLEAN);
    run_mixed(100);

    wait_drain();
    write_max_len(8'd1);
    run_mixed(100);

    wait_drain();
    write_max_len(8'($urandom_range(2, 254)));
    steady = 1'b1;
    run_mixed(80);
    steady = 1'b0;
    run_mixed(60);

    wait_drain();
    write_max_len(8'd16);
    run_mixed(120);

    wait_drain();
    repeat (20) @(posedge clk);
    if (book.errors == 0 && book.pending_count() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
